FILE: sv/ymr_pkg.sv
package ymr_pkg;

  // Input opcodes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_ABORT   = 2'd3;

  // Protocol bytes
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_CRQ = 8'h43;
  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_SPC = 8'h20;
  localparam logic [7:0] BYTE_D0  = 8'h30;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_MSB   = 16'h8000;
  localparam logic [30:0] SIZE_MAX  = 31'h7FFF_FFFF;
  localparam logic [23:0] TIMEOUT_RST = 24'd10000;

  typedef struct packed {
    logic [1:0] opcode;
    logic       packet_start;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  reply_byte;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_offset;
    logic [10:0] commit_length;
    logic        packet_ok;
    logic [30:0] declared_size;
    logic        last;
  } result_t;

  // Results produced by one accepted item.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_HEADER = 3'b010,
    MODE_DATA   = 3'b100
  } mode_t;

  typedef enum logic [2:0] {
    PK_NONE  = 3'b001,
    PK_SHORT = 3'b010,
    PK_LONG  = 3'b100
  } pkind_t;

  typedef enum logic [2:0] {
    HP_NAME   = 3'b001,
    HP_DIGITS = 3'b010,
    HP_DONE   = 3'b100
  } hphase_t;

  // CRC-16/XMODEM update by one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/ymr_core.sv
module ymr_core import ymr_pkg::*; #(
  parameter int LONG_PAYLOAD  = 1024,
  parameter int SHORT_PAYLOAD = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  in_item_t     item,
  input  logic         cfg_we,
  input  logic [23:0]  cfg_wdata,
  output result_pair_t results
);

  localparam int MAXP  = (LONG_PAYLOAD > SHORT_PAYLOAD) ? LONG_PAYLOAD : SHORT_PAYLOAD;
  localparam int POS_W = $clog2(MAXP + 5);
  localparam logic [POS_W-1:0] PLEN_LONG  = POS_W'(LONG_PAYLOAD);
  localparam logic [POS_W-1:0] PLEN_SHORT = POS_W'(SHORT_PAYLOAD);
  localparam logic [POS_W-1:0] HDR_LEN    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_ONE    = POS_W'(1);

  mode_t             mode_r, mode_nxt;
  pkind_t            pkind_r, pkind_nxt;
  hphase_t           hphase_r, hphase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [15:0]       crc_run_r, crc_run_nxt;
  logic [15:0]       crc_rcv_r, crc_rcv_nxt;
  logic [30:0]       remain_r, remain_nxt;
  logic [30:0]       size_r, size_nxt;
  logic [23:0]       idle_r, idle_nxt;
  logic [23:0]       timeout_r;

  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  plen;
  logic [POS_W-1:0]  off;
  logic [15:0]       crc_upd;
  logic [34:0]       size_sum;
  logic [24:0]       tick_cnt;
  logic [30:0]       commit;
  logic [15:0]       crc_full;

  assign pos_inc  = pos_r + POS_ONE;
  assign plen     = (pkind_r == PK_SHORT) ? PLEN_SHORT : PLEN_LONG;
  assign off      = pos_inc - HDR_LEN;
  assign crc_upd  = crc16_byte(crc_run_r, item.data_byte);
  assign size_sum = ({4'b0, size_r} << 3) + ({4'b0, size_r} << 1)
                  + {27'b0, item.data_byte - BYTE_D0};
  assign tick_cnt = {1'b0, idle_r} + 25'd1;
  assign commit   = (remain_r < 31'(plen)) ? remain_r : 31'(plen);
  assign crc_full = {crc_rcv_r[15:8], item.data_byte};

  always_comb begin
    mode_nxt    = mode_r;
    pkind_nxt   = pkind_r;
    hphase_nxt  = hphase_r;
    pos_nxt     = pos_r;
    crc_run_nxt = crc_run_r;
    crc_rcv_nxt = crc_rcv_r;
    remain_nxt  = remain_r;
    size_nxt    = size_r;
    idle_nxt    = idle_r;
    results     = '0;

    case (item.opcode)
      OP_START: begin
        mode_nxt  = MODE_HEADER;
        pkind_nxt = PK_NONE;
        pos_nxt   = '0;
        idle_nxt  = '0;
      end
      OP_TICK: begin
        if (mode_r != MODE_IDLE) begin
          if (tick_cnt > {1'b0, timeout_r}) begin
            mode_nxt  = MODE_IDLE;
            pkind_nxt = PK_NONE;
            idle_nxt  = '0;
            results.count = 2'd1;
            results.first.result_kind = KIND_ABORT;
          end else begin
            idle_nxt = tick_cnt[23:0];
          end
        end
      end
      OP_BYTE: begin
        if (mode_r != MODE_IDLE) begin
          if (item.packet_start) begin
            pkind_nxt = PK_NONE;
            pos_nxt   = '0;
            if (item.data_byte == BYTE_SOH || item.data_byte == BYTE_STX) begin
              pkind_nxt   = (item.data_byte == BYTE_SOH) ? PK_SHORT : PK_LONG;
              crc_run_nxt = '0;
              crc_rcv_nxt = '0;
              hphase_nxt  = HP_NAME;
              if (mode_r == MODE_HEADER) begin
                size_nxt = '0;
              end
              idle_nxt = '0;
            end else if (item.data_byte == BYTE_EOT && mode_r == MODE_DATA) begin
              idle_nxt = '0;
              mode_nxt = MODE_IDLE;
              results.count = 2'd2;
              results.first.result_kind  = KIND_REPLY;
              results.first.reply_byte   = BYTE_ACK;
              results.second.result_kind = KIND_DONE;
            end
          end else if (pkind_r != PK_NONE) begin
            pos_nxt = pos_inc;
            if (pos_inc >= HDR_LEN && pos_inc < HDR_LEN + plen) begin
              crc_run_nxt = crc_upd;
              if (mode_r == MODE_HEADER) begin
                case (hphase_r)
                  HP_NAME: begin
                    if (item.data_byte == BYTE_NUL || item.data_byte == BYTE_SPC) begin
                      hphase_nxt = HP_DIGITS;
                    end
                  end
                  HP_DIGITS: begin
                    if (item.data_byte inside {[8'h30:8'h39]}) begin
                      size_nxt = (size_sum > {4'b0, SIZE_MAX}) ? SIZE_MAX : size_sum[30:0];
                    end else begin
                      hphase_nxt = HP_DONE;
                    end
                  end
                  default: begin
                  end
                endcase
              end else begin
                results.count = 2'd1;
                results.first.result_kind    = KIND_PAYLOAD;
                results.first.payload_byte   = item.data_byte;
                results.first.payload_offset = off[9:0];
              end
            end else if (pos_inc == HDR_LEN + plen) begin
              crc_rcv_nxt = {item.data_byte, 8'h00};
            end else if (pos_inc == HDR_LEN + plen + POS_ONE) begin
              crc_rcv_nxt = crc_full;
              pkind_nxt   = PK_NONE;
              idle_nxt    = '0;
              if (mode_r == MODE_HEADER) begin
                remain_nxt = size_r;
                mode_nxt   = MODE_DATA;
                results.count = 2'd2;
                results.first.result_kind    = KIND_REPLY;
                results.first.reply_byte     = BYTE_ACK;
                results.first.declared_size  = size_r;
                results.second.result_kind   = KIND_REPLY;
                results.second.reply_byte    = BYTE_CRQ;
                results.second.declared_size = size_r;
              end else if (crc_full == crc_run_r) begin
                remain_nxt = remain_r - commit;
                results.count = 2'd1;
                results.first.result_kind   = KIND_REPLY;
                results.first.reply_byte    = BYTE_ACK;
                results.first.commit_length = commit[10:0];
                results.first.packet_ok     = 1'b1;
              end else begin
                results.count = 2'd1;
                results.first.result_kind = KIND_REPLY;
                results.first.reply_byte  = BYTE_NAK;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (results.count == 2'd1) begin
      results.first.last = 1'b1;
    end else if (results.count == 2'd2) begin
      results.second.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      pkind_r   <= PK_NONE;
      hphase_r  <= HP_NAME;
      pos_r     <= '0;
      crc_run_r <= '0;
      crc_rcv_r <= '0;
      remain_r  <= '0;
      size_r    <= '0;
      idle_r    <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      pkind_r   <= pkind_nxt;
      hphase_r  <= hphase_nxt;
      pos_r     <= pos_nxt;
      crc_run_r <= crc_run_nxt;
      crc_rcv_r <= crc_rcv_nxt;
      remain_r  <= remain_nxt;
      size_r    <= size_nxt;
      idle_r    <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // A packet can only be open while a transfer session is active.
  a_pkind_needs_session: assert property (@(posedge clk) disable iff (!rst_n)
    pkind_r != PK_NONE |-> mode_r != MODE_IDLE)
    else $error("packet open while idle");

  a_start_enters_header: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.opcode == OP_START |=> mode_r == MODE_HEADER && pkind_r == PK_NONE)
    else $error("start command did not enter header mode");

  // Only the final result of an item carries the last flag.
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    results.count == 2'd2 |-> !results.first.last && results.second.last)
    else $error("last flag misplaced in result pair");

endmodule

FILE: sv/ymr_out_fifo.sv
module ymr_out_fifo import ymr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  result_pair_t push_data,
  output logic         room2,
  output logic         out_valid,
  input  logic         out_ready,
  output result_t      out_data
);

  localparam int DEPTH = 4;

  result_t      mem_r [DEPTH];
  logic [1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [2:0]   count_r, count_nxt;
  logic [1:0]   n_push;
  logic         pop;

  assign n_push    = push ? push_data.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 3'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room2     = (count_r <= 3'(DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + n_push;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign count_nxt  = count_r + {1'b0, n_push} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push_data.first;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push_data.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    n_push != 2'd0 |-> count_r <= 3'(DEPTH - 2))
    else $error("result queue written without room");

  // Fill level and pointers must stay consistent.
  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(DEPTH) && (wr_ptr_r - rd_ptr_r) == count_r[1:0])
    else $error("result queue pointers out of step");

endmodule

FILE: sv/ymodem_packet_receiver.sv
// Channel   Ports                          Direction  Payload
// input     in_valid, in_ready, in_data    in         in_item_t (opcode, start, byte)
// result    out_valid, out_ready, out_data out        result_t (one result per transfer)
// config    cfg_we, cfg_wdata              in         timeout_ticks, 24 bits
//
// An accepted item is processed in the cycle of its transfer; its results enter
// a four-entry result queue, and into an empty queue the first shows next cycle.
// One item per cycle is sustained while the queue holds at most two results,
// so items giving two results (header end, EOT) are paced by output drain.
// Reset (synchronous, rst_n low) clears the session state and empties the queue.
// out_ready low stalls results; in_ready drops once fewer than two slots remain.
module ymodem_packet_receiver import ymr_pkg::*; #(
  parameter int LONG_PAYLOAD  = 1024,
  parameter int SHORT_PAYLOAD = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  logic         accept;
  result_pair_t results;
  logic         room2;

  assign in_ready = room2;
  assign accept   = in_valid && in_ready;

  ymr_core #(
    .LONG_PAYLOAD  (LONG_PAYLOAD),
    .SHORT_PAYLOAD (SHORT_PAYLOAD)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .results   (results)
  );

  ymr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (results),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: bench/testbench.sv
module testbench;
  import ymr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_LEN = 1024;
  localparam int SHORT_LEN = 128;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SQUEEZE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_data;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;

  ymodem_packet_receiver #(
    .LONG_PAYLOAD(LONG_LEN),
    .SHORT_PAYLOAD(SHORT_LEN)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver state as the testbench tracks it.
  logic [23:0] rx_timeout = TIMEOUT_RST;
  mode_t rx_mode = MODE_IDLE;
  pkind_t rx_kind = PK_NONE;
  hphase_t rx_phase = HP_NAME;
  int unsigned rx_pos = 0;
  logic [15:0] rx_crc = '0;
  logic [15:0] rx_crc_got = '0;
  logic [30:0] rx_remaining = '0;
  logic [30:0] rx_size = '0;
  logic [23:0] rx_idle = '0;

  in_item_t pending_items[$];
  result_t expected_results[$];
  logic [7:0] body_bytes[$];

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned phase_items = 0;
  int unsigned tick_permille = 5;
  int error_count = 0;

  function automatic logic [15:0] crc_xmodem_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] reply,
                                          input logic [7:0] pbyte, input logic [9:0] poff,
                                          input logic [10:0] commit, input logic ok,
                                          input logic [30:0] size);
    result_t r;
    r = '0;
    r.result_kind = kind;
    r.reply_byte = reply;
    r.payload_byte = pbyte;
    r.payload_offset = poff;
    r.commit_length = commit;
    r.packet_ok = ok;
    r.declared_size = size;
    return r;
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf("kind=%0d reply=%h byte=%h off=%0d commit=%0d ok=%0b size=%0d last=%0b",
                     r.result_kind, r.reply_byte, r.payload_byte, r.payload_offset,
                     r.commit_length, r.packet_ok, r.declared_size, r.last);
  endfunction

  // Updates the tracked receiver state for one accepted item and queues the
  // results it must produce.
  function automatic void advance_receiver(input in_item_t it);
    result_t r[2];
    int n;
    int unsigned plen;
    int unsigned ticks;
    longint unsigned acc;
    logic [10:0] commit;
    logic [7:0] b;
    n = 0;
    b = it.data_byte;
    case (it.opcode)
      OP_START: begin
        rx_mode = MODE_HEADER;
        rx_kind = PK_NONE;
        rx_pos = 0;
        rx_idle = '0;
      end
      OP_TICK: begin
        if (rx_mode != MODE_IDLE) begin
          ticks = 32'(rx_idle) + 1;
          if (ticks > 32'(rx_timeout)) begin
            rx_mode = MODE_IDLE;
            rx_kind = PK_NONE;
            rx_idle = '0;
            r[n] = make_result(KIND_ABORT, 8'h00, 8'h00, '0, '0, 1'b0, '0);
            n++;
          end else begin
            rx_idle = 24'(ticks);
          end
        end
      end
      OP_BYTE: begin
        if (rx_mode != MODE_IDLE && it.packet_start) begin
          rx_kind = PK_NONE;
          rx_pos = 0;
          if (b == BYTE_SOH || b == BYTE_STX) begin
            rx_kind = (b == BYTE_SOH) ? PK_SHORT : PK_LONG;
            rx_crc = '0;
            rx_crc_got = '0;
            rx_phase = HP_NAME;
            if (rx_mode == MODE_HEADER) begin
              rx_size = '0;
            end
            rx_idle = '0;
          end else if (b == BYTE_EOT && rx_mode == MODE_DATA) begin
            rx_idle = '0;
            rx_mode = MODE_IDLE;
            r[n] = make_result(KIND_REPLY, BYTE_ACK, 8'h00, '0, '0, 1'b0, '0);
            n++;
            r[n] = make_result(KIND_DONE, 8'h00, 8'h00, '0, '0, 1'b0, '0);
            n++;
          end
        end else if (rx_mode != MODE_IDLE && rx_kind != PK_NONE) begin
          plen = (rx_kind == PK_SHORT) ? SHORT_LEN : LONG_LEN;
          rx_pos++;
          if (rx_pos >= 3 && rx_pos < 3 + plen) begin
            rx_crc = crc_xmodem_step(rx_crc, b);
            if (rx_mode == MODE_HEADER) begin
              // Size field: decimal digits after the name, saturating.
              if (rx_phase == HP_NAME) begin
                if (b == BYTE_NUL || b == BYTE_SPC) begin
                  rx_phase = HP_DIGITS;
                end
              end else if (rx_phase == HP_DIGITS) begin
                if (b >= BYTE_D0 && b <= BYTE_D0 + 8'd9) begin
                  acc = 64'(rx_size) * 64'd10 + 64'(b - BYTE_D0);
                  rx_size = (acc > 64'(SIZE_MAX)) ? SIZE_MAX : 31'(acc);
                end else begin
                  rx_phase = HP_DONE;
                end
              end
            end else begin
              r[n] = make_result(KIND_PAYLOAD, 8'h00, b, 10'(rx_pos - 3), '0, 1'b0, '0);
              n++;
            end
          end else if (rx_pos == 3 + plen) begin
            rx_crc_got = {b, 8'h00};
          end else if (rx_pos == 4 + plen) begin
            rx_crc_got[7:0] = b;
            rx_kind = PK_NONE;
            rx_idle = '0;
            if (rx_mode == MODE_HEADER) begin
              rx_remaining = rx_size;
              rx_mode = MODE_DATA;
              r[n] = make_result(KIND_REPLY, BYTE_ACK, 8'h00, '0, '0, 1'b0, rx_size);
              n++;
              r[n] = make_result(KIND_REPLY, BYTE_CRQ, 8'h00, '0, '0, 1'b0, rx_size);
              n++;
            end else if (rx_crc_got == rx_crc) begin
              commit = (32'(rx_remaining) < plen) ? rx_remaining[10:0] : 11'(plen);
              rx_remaining = rx_remaining - 31'(commit);
              r[n] = make_result(KIND_REPLY, BYTE_ACK, 8'h00, '0, commit, 1'b1, '0);
              n++;
            end else begin
              r[n] = make_result(KIND_REPLY, BYTE_NAK, 8'h00, '0, '0, 1'b0, '0);
              n++;
            end
          end
        end
      end
      default: begin
      end
    endcase
    for (int k = 0; k < n; k++) begin
      r[k].last = (k == n - 1);
      expected_results.push_back(r[k]);
    end
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic start, input logic [7:0] b);
    in_item_t it;
    it.opcode = op;
    it.packet_start = start;
    it.data_byte = b;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_tick();
    queue_item(OP_TICK, 1'($urandom), 8'($urandom));
  endtask

  task automatic queue_tick_burst();
    int unsigned len;
    len = (rx_timeout < 40) ? $urandom_range(0, 32'(rx_timeout) + 2) : $urandom_range(1, 6);
    repeat (len) queue_tick();
  endtask

  // Junk between packets: stray bytes, a packet with an unknown first byte,
  // or a run of ticks.
  task automatic queue_noise();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: begin
        repeat ($urandom_range(1, 3)) queue_item(OP_BYTE, 1'b0, 8'($urandom));
      end
      1: begin
        b = 8'($urandom);
        if (b == BYTE_SOH || b == BYTE_STX || b == BYTE_EOT) begin
          b = b ^ 8'h80;
        end
        queue_item(OP_BYTE, 1'b1, b);
        repeat ($urandom_range(0, 4)) queue_item(OP_BYTE, 1'b0, 8'($urandom));
      end
      default: queue_tick_burst();
    endcase
  endtask

  // Header payload: name, NUL or space, decimal size, a non-digit, padding; or a name alone.
  task automatic build_header_body(input int unsigned plen, input int unsigned force_digits);
    int unsigned digits;
    int unsigned pick;
    logic [7:0] b;
    body_bytes.delete();
    repeat ($urandom_range(0, 12)) begin
      b = 8'($urandom_range(1, 255));
      body_bytes.push_back((b == BYTE_SPC) ? 8'h5F : b);
    end
    pick = $urandom_range(0, 9);
    if (pick == 0 && force_digits == 0) begin
      // The name runs to the end of the field, so no size is ever parsed.
      while (body_bytes.size() < plen) body_bytes.push_back(8'h41 + 8'($urandom_range(0, 25)));
    end else begin
      body_bytes.push_back(pick < 5 ? BYTE_NUL : BYTE_SPC);
      pick = $urandom_range(0, 9);
      if (force_digits != 0) begin
        digits = force_digits;
      end else if (pick == 0) begin
        digits = 0;
      end else if (pick == 1) begin
        digits = $urandom_range(10, 16);
      end else if (pick < 5) begin
        digits = $urandom_range(1, 2);
      end else begin
        digits = $urandom_range(3, 4);
      end
      repeat (digits) body_bytes.push_back(BYTE_D0 + 8'($urandom_range(0, 9)));
      b = 8'($urandom);
      body_bytes.push_back((b >= BYTE_D0 && b <= BYTE_D0 + 8'd9) ? BYTE_SPC : b);
      pick = $urandom_range(0, 1);
      while (body_bytes.size() < plen) body_bytes.push_back(pick ? 8'($urandom) : BYTE_NUL);
    end
  endtask

  // Sends body_bytes as one packet. A truncated packet stops short of its end.
  task automatic queue_packet(input logic [7:0] lead, input bit good_crc, input bit truncate);
    logic [7:0] frame[$];
    logic [15:0] crc;
    logic [7:0] blk;
    int unsigned keep;
    blk = 8'($urandom);
    crc = 16'h0000;
    frame.push_back(blk);
    frame.push_back(~blk);
    foreach (body_bytes[i]) begin
      frame.push_back(body_bytes[i]);
      crc = crc_xmodem_step(crc, body_bytes[i]);
    end
    if (!good_crc) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    keep = truncate ? $urandom_range(0, frame.size() - 1) : frame.size();
    queue_item(OP_BYTE, 1'b1, lead);
    for (int i = 0; i < keep; i++) begin
      if ($urandom_range(0, 999) < tick_permille) begin
        queue_tick();
      end
      queue_item(OP_BYTE, 1'b0, frame[i]);
    end
    phase_items += keep + 1;
  endtask

  task automatic queue_session(input bit long_header, input bit long_data);
    logic [7:0] lead;
    int unsigned npk;
    if ($urandom_range(0, 3) == 0) queue_noise();
    queue_item(OP_START, 1'($urandom), 8'($urandom));
    if ($urandom_range(0, 3) == 0) queue_noise();
    lead = long_header ? BYTE_STX : BYTE_SOH;
    build_header_body(long_header ? LONG_LEN : SHORT_LEN, long_data ? 6 : 0);
    if ($urandom_range(0, 7) == 0) queue_packet(lead, 1'b1, 1'b1);
    queue_packet(lead, $urandom_range(0, 3) != 0, 1'b0);
    npk = long_data ? 1 : $urandom_range(1, 3);
    for (int p = 0; p < npk; p++) begin
      lead = long_data ? BYTE_STX : BYTE_SOH;
      body_bytes.delete();
      repeat (long_data ? LONG_LEN : SHORT_LEN) body_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 4) == 0) queue_noise();
      if ($urandom_range(0, 7) == 0) queue_packet(lead, 1'b1, 1'b1);
      queue_packet(lead, long_data || $urandom_range(0, 4) != 0, 1'b0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) queue_item(OP_BYTE, 1'b0, 8'($urandom));
      end
      if ($urandom_range(0, 5) == 0) queue_tick_burst();
    end
    if ($urandom_range(0, 19) == 0) queue_item(OP_START, 1'($urandom), 8'($urandom));
    if ($urandom_range(0, 9) != 0) begin
      queue_item(OP_BYTE, 1'b1, BYTE_EOT);
    end else begin
      queue_tick_burst();
    end
  endtask

  // Three restarts, each followed by a burst of ticks that may pass a limit below 40.
  task automatic queue_timeout_probe();
    repeat (3) begin
      queue_item(OP_START, 1'($urandom), 8'($urandom));
      queue_tick_burst();
    end
  endtask

  task automatic wait_until_drained();
    while (items_taken != items_queued || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: offers queued items, with random gaps between transfers.
  int unsigned send_gap = 0;
  int send_stretch = 0;
  bit send_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_receiver(in_data);
        items_taken++;
      end
      if (send_stretch <= 0) begin
        send_stretch = $urandom_range(128, 512);
        send_calm = ($urandom_range(0, 3) == 0);
      end
      send_stretch--;
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap = send_calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: checks every transfer and stalls at random. Now and then it
  // holds off for a long stretch so that the result queue fills up.
  result_t want;
  int unsigned hold_left = 0;
  int recv_stretch = 0;
  bit recv_calm = 1'b0;
  int unsigned next_squeeze = 100;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          if (error_count < 10) $display("unexpected result: %s", describe(out_data));
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_kind !== want.result_kind
              || out_data.reply_byte !== want.reply_byte
              || out_data.payload_byte !== want.payload_byte
              || out_data.payload_offset !== want.payload_offset
              || out_data.commit_length !== want.commit_length
              || out_data.packet_ok !== want.packet_ok
              || out_data.declared_size !== want.declared_size
              || out_data.last !== want.last) begin
            if (error_count < 10) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(out_data));
            end
            error_count++;
          end
        end
      end
      if (results_seen >= next_squeeze) begin
        hold_left = SQUEEZE_CYCLES;
        next_squeeze += 1000;
      end
      if (recv_stretch <= 0) begin
        recv_stretch = $urandom_range(128, 512);
        recv_calm = ($urandom_range(0, 3) == 0);
      end
      recv_stretch--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold_left = recv_calm ? 0 : pick_gap();
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  logic [23:0] timeout_plan[5];

  initial begin
    timeout_plan[0] = TIMEOUT_RST;
    timeout_plan[1] = 24'd1;
    timeout_plan[2] = 24'hFFFFFF;
    timeout_plan[3] = 24'd4;
    timeout_plan[4] = 24'd25;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Idle mode ignores bytes and ticks.
    queue_item(OP_TICK, 1'b0, 8'h00);
    queue_item(OP_BYTE, 1'b1, BYTE_SOH);
    queue_item(OP_BYTE, 1'b0, 8'hFF);
    queue_item(OP_BYTE, 1'b1, BYTE_EOT);
    // EOT while waiting for the header is ignored, as is an unknown lead byte.
    queue_item(OP_START, 1'b1, 8'hFF);
    queue_item(OP_BYTE, 1'b1, BYTE_EOT);
    queue_item(OP_BYTE, 1'b1, 8'hFF);
    queue_item(OP_BYTE, 1'b0, 8'h00);
    queue_item(OP_BYTE, 1'b0, 8'hFF);
    queue_item(OP_BYTE, 1'b1, 8'h00);
    queue_item(OP_BYTE, 1'b0, 8'h7E);
    queue_item(OP_TICK, 1'b1, 8'hFF);
    queue_item(OP_TICK, 1'b0, 8'h00);
    // A restart while busy, then a packet cut short by a new packet start.
    queue_item(OP_START, 1'b0, 8'h00);
    queue_item(OP_BYTE, 1'b1, BYTE_SOH);
    queue_item(OP_BYTE, 1'b0, 8'h01);
    queue_item(OP_BYTE, 1'b0, 8'hFE);
    queue_item(OP_BYTE, 1'b0, 8'h41);
    queue_item(OP_BYTE, 1'b1, BYTE_STX);
    queue_item(OP_BYTE, 1'b0, 8'h00);
    queue_item(OP_BYTE, 1'b0, 8'hFF);
    queue_item(OP_START, 1'b1, 8'h55);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        wait_until_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= timeout_plan[p];
        rx_timeout = timeout_plan[p];
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      tick_permille = (timeout_plan[p] == 24'd1) ? 2 : 6;
      phase_items = 0;
      // Full sessions run at the default and the moderate limit; the other
      // limits only get short restart and tick probes.
      if (timeout_plan[p] == TIMEOUT_RST || timeout_plan[p] == 24'd25) begin
        while (phase_items < 160) queue_session(1'b0, 1'b0);
      end else begin
        queue_timeout_probe();
      end
    end

    wait_until_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ymr_pkg.sv
sv/ymr_core.sv
sv/ymr_out_fifo.sv
sv/ymodem_packet_receiver.sv
bench/testbench.sv
